FILE: src/fcod_pkg.sv
// Shared types and constants for the flow cycle-off detector.
package fcod_pkg;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned FlowW    = 16;
  localparam int unsigned PeakW    = 15;
  localparam int unsigned CountW   = 8;
  localparam int unsigned PctW     = 7;
  localparam int unsigned TimeW    = 32;

  // flow * 100 fits in 24 signed bits, peak * percent in 22 unsigned bits
  localparam int unsigned ScaledW  = 24;
  localparam int unsigned ThreshW  = PeakW + PctW;

  localparam logic [PeakW-1:0]   MinPeakRst  = PeakW'(1000);
  localparam logic [CountW-1:0]  ConfirmRst  = CountW'(3);
  localparam logic [ScaledW-1:0] PctScale    = ScaledW'(100);

  localparam logic ReasonMaxTime = 1'b0;
  localparam logic ReasonFlow    = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_PEAK_FLOW  = 8'd0,
    REG_CONFIRM_NEEDED = 8'd1
  } fcod_reg_e;

  typedef struct packed {
    logic [TimeW-1:0]        now_ms;
    logic                    in_inspiration;
    logic                    plan_eligible;
    logic [TimeW-1:0]        plan_sequence;
    logic [TimeW-1:0]        max_insp_time_ms;
    logic [TimeW-1:0]        rise_time_ms;
    logic [TimeW-1:0]        min_insp_time_ms;
    logic [PctW-1:0]         cycle_off_percent;
    logic signed [FlowW-1:0] flow;
    logic                    flow_valid;
    logic                    cycle_accepted;
  } fcod_in_t;

  typedef struct packed {
    logic              cycle_request;
    logic              cycle_reason;
    logic              tracking;
    logic [PeakW-1:0]  peak_flow;
    logic [CountW-1:0] confirm_count;
  } fcod_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] wdata;
  } fcod_cfg_wr_t;

  typedef struct packed {
    logic [PeakW-1:0]  min_peak_flow;
    logic [CountW-1:0] confirm_count_needed;
  } fcod_cfg_t;

endpackage

FILE: src/fcod_if.sv
// Valid/ready channel interfaces for the detector's input, result and config words.
interface fcod_in_if;
  logic              valid;
  logic              ready;
  fcod_pkg::fcod_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fcod_out_if;
  logic               valid;
  logic               ready;
  fcod_pkg::fcod_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fcod_cfg_if;
  logic                  valid;
  logic                  ready;
  fcod_pkg::fcod_cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/fcod_cfg.sv
// Configuration register file: minimum peak flow and confirm count.
module fcod_cfg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  fcod_pkg::fcod_cfg_wr_t wr_i,
  output fcod_pkg::fcod_cfg_t    cfg_o
);
  import fcod_pkg::*;

  logic [PeakW-1:0]  min_peak_q, min_peak_d;
  logic [CountW-1:0] need_q, need_d;

  always_comb begin
    min_peak_d = min_peak_q;
    need_d     = need_q;
    if (wr_en_i) begin
      unique case (fcod_reg_e'(wr_i.index))
        REG_MIN_PEAK_FLOW:  min_peak_d = wr_i.wdata[PeakW-1:0];
        REG_CONFIRM_NEEDED: need_d     = wr_i.wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_peak_q <= MinPeakRst;
      need_q     <= ConfirmRst;
    end else begin
      min_peak_q <= min_peak_d;
      need_q     <= need_d;
    end
  end

  assign cfg_o.min_peak_flow        = min_peak_q;
  assign cfg_o.confirm_count_needed = need_q;

endmodule

FILE: src/fcod_step.sv
// Tracking state and the per-tick cycle-off decision logic.
module fcod_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  fcod_pkg::fcod_in_t  item_i,
  input  fcod_pkg::fcod_cfg_t cfg_i,
  output fcod_pkg::fcod_out_t res_o
);
  import fcod_pkg::*;

  logic              trk_q, trk_d;
  logic [TimeW-1:0]  seq_q, seq_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic [PeakW-1:0]  peak_q, peak_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  logic                      restart;
  logic                      go_idle;
  logic                      req;
  logic                      reason;
  logic [TimeW-1:0]          start_cur;
  logic [PeakW-1:0]          peak_cur;
  logic [PeakW-1:0]          peak_new;
  logic [CountW-1:0]         cnt_cur;
  logic [CountW-1:0]         cnt_inc;
  logic [TimeW-1:0]          elapsed;
  logic signed [ScaledW-1:0] flow_scaled;
  logic [ThreshW-1:0]        thresh;
  logic                      above;
  logic                      armed;

  // Fresh tracking on first eligible tick or a new plan
  assign restart   = !trk_q || (seq_q != item_i.plan_sequence);
  assign start_cur = restart ? item_i.now_ms : start_q;
  assign peak_cur  = restart ? '0 : peak_q;
  assign cnt_cur   = restart ? '0 : cnt_q;
  assign elapsed   = item_i.now_ms - start_cur;

  assign peak_new = ($signed(item_i.flow) > $signed({1'b0, peak_cur})) ?
                    item_i.flow[PeakW-1:0] : peak_cur;

  assign flow_scaled = $signed(ScaledW'($signed(item_i.flow))) * $signed(PctScale);
  assign thresh      = ThreshW'(peak_new) * ThreshW'(item_i.cycle_off_percent);
  assign above       = flow_scaled > $signed({{(ScaledW-ThreshW){1'b0}}, thresh});

  assign armed = (elapsed >= item_i.rise_time_ms) &&
                 (elapsed >= item_i.min_insp_time_ms) &&
                 (peak_new >= cfg_i.min_peak_flow);

  assign cnt_inc = (cnt_cur < cfg_i.confirm_count_needed) ? cnt_cur + CountW'(1) : cnt_cur;

  always_comb begin
    trk_d   = 1'b1;
    seq_d   = item_i.plan_sequence;
    start_d = start_cur;
    peak_d  = peak_cur;
    cnt_d   = cnt_cur;
    req     = 1'b0;
    reason  = ReasonMaxTime;
    go_idle = 1'b0;
    if (!(item_i.in_inspiration && item_i.plan_eligible)) begin
      go_idle = 1'b1;
    end else if (elapsed >= item_i.max_insp_time_ms) begin
      req     = 1'b1;
      reason  = ReasonMaxTime;
      go_idle = item_i.cycle_accepted;
    end else if (!item_i.flow_valid) begin
      cnt_d = '0;
    end else begin
      peak_d = peak_new;
      if (armed) begin
        if (above) begin
          cnt_d = '0;
        end else begin
          cnt_d = cnt_inc;
          if (cnt_inc >= cfg_i.confirm_count_needed) begin
            req     = 1'b1;
            reason  = ReasonFlow;
            go_idle = item_i.cycle_accepted;
          end
        end
      end
    end
    if (go_idle) begin
      trk_d   = 1'b0;
      seq_d   = '0;
      start_d = '0;
      peak_d  = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q   <= 1'b0;
      seq_q   <= '0;
      start_q <= '0;
      peak_q  <= '0;
      cnt_q   <= '0;
    end else if (fire_i) begin
      trk_q   <= trk_d;
      seq_q   <= seq_d;
      start_q <= start_d;
      peak_q  <= peak_d;
      cnt_q   <= cnt_d;
    end
  end

  assign res_o.cycle_request = req;
  assign res_o.cycle_reason  = reason;
  assign res_o.tracking      = trk_d;
  assign res_o.peak_flow     = peak_d;
  assign res_o.confirm_count = cnt_d;

  // idle means every tracking field is cleared
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !trk_q |-> (peak_q == '0) && (cnt_q == '0) && (seq_q == '0) && (start_q == '0))
    else $error("idle state not cleared");

  // accepted request drops tracking
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req && item_i.cycle_accepted |=> !trk_q)
    else $error("accepted request left block tracking");

  // ineligible tick drops tracking
  a_inelig_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !(item_i.in_inspiration && item_i.plan_eligible) |=> !trk_q)
    else $error("ineligible tick left block tracking");

  // flow reason only on a request
  a_reason_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && reason |-> req)
    else $error("flow reason without request");

endmodule

FILE: src/flow_cycle_off_detector_unit.sv
// Top level of the pressure-support flow cycle-off detector.
//
//  channel  | dir | word                       | notes
//  ---------+-----+----------------------------+-------------------------------
//  in_i     | in  | one ms tick: time, plan,   | accepted when valid && ready
//           |     | flow sample, acceptance    |
//  out_o    | out | request, reason, tracking, | one word per input word
//           |     | peak flow, confirm count   |
//  cfg_i    | in  | register index + data      | always ready; 0 min peak flow,
//           |     |                            | 1 confirm count needed
//
// Cycles: one word per clock sustained while out_o is not held off. A word
// is registered in the input register, the decision logic runs from there
// into the result register, and the result is offered on out_o from the
// result register.
// The tracking state updates at the edge the word moves into the result
// register, so each tick sees the state its predecessor left.
// Stalls: when out_o is held off, the result register holds and the input
// register fills; in_i.ready drops only when both are full.
// Reset (rst_ni low, async) empties both registers, idles the tracker and
// loads min peak flow 1000 and confirm count 3.
module flow_cycle_off_detector_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  fcod_in_if.sink    in_i,
  fcod_out_if.source out_o,
  fcod_cfg_if.sink   cfg_i
);
  import fcod_pkg::*;

  logic      in_valid_q, in_valid_d;
  fcod_in_t  in_data_q, in_data_d;
  logic      out_valid_q, out_valid_d;
  fcod_out_t out_data_q, out_data_d;

  logic      advance;   // result register can take a word
  logic      fire;      // word moves input reg -> result reg
  logic      in_take;
  fcod_cfg_t cfg;
  fcod_out_t res;

  assign advance  = !out_valid_q || out_o.ready;
  assign fire     = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  fcod_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_i.valid),
    .wr_i    (cfg_i.data),
    .cfg_o   (cfg)
  );

  fcod_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    in_data_d  = in_data_q;
    if (in_take) begin
      in_valid_d = 1'b1;
      in_data_d  = in_i.data;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (advance) begin
      out_valid_d = fire;
      out_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    in_data_q  <= in_data_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // a word in the input register always moves on when the result side frees
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |=> out_valid_q)
    else $error("pending word not moved to result register");

  // result register only loads from a pending word
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q && !in_valid_q |=> !out_valid_q)
    else $error("result appeared without a pending word");

  // a stalled full pipe accepts nothing
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input taken while pipe full and stalled");

endmodule

FILE: verif/cycle_off_checker.sv
// Checker for the flow cycle-off detector: predicts each result word and compares it.
`timescale 1ns / 1ps

module cycle_off_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  fcod_in_if          in_ch,
  fcod_out_if         out_ch,
  fcod_cfg_if         cfg_ch,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  import fcod_pkg::*;

  // shadow registers
  logic [PeakW-1:0]  min_peak;
  logic [CountW-1:0] count_needed;

  // shadow tracker
  logic              trk_active;
  logic [TimeW-1:0]  trk_seq;
  logic [TimeW-1:0]  trk_start;
  int                trk_peak;
  logic [CountW-1:0] trk_count;

  fcod_out_t pending_words[$];

  function automatic void clear_tracker();
    trk_active = 1'b0;
    trk_seq    = '0;
    trk_start  = '0;
    trk_peak   = 0;
    trk_count  = '0;
  endfunction

  // One tick through the detector; updates the shadow tracker.
  function automatic fcod_out_t decide_tick(input fcod_in_t w);
    fcod_out_t        r;
    logic [TimeW-1:0] elapsed;
    int               f;
    r = '0;
    f = $signed(w.flow);
    if (!w.in_inspiration || !w.plan_eligible) begin
      clear_tracker();
    end else begin
      if (!trk_active || trk_seq != w.plan_sequence) begin
        trk_active = 1'b1;
        trk_seq    = w.plan_sequence;
        trk_start  = w.now_ms;
        trk_peak   = 0;
        trk_count  = '0;
      end
      elapsed = w.now_ms - trk_start;
      if (elapsed >= w.max_insp_time_ms) begin
        r.cycle_request = 1'b1;
        r.cycle_reason  = ReasonMaxTime;
        if (w.cycle_accepted) clear_tracker();
      end else if (!w.flow_valid) begin
        trk_count = '0;
      end else begin
        if (f > trk_peak) trk_peak = f;
        if (elapsed >= w.rise_time_ms && elapsed >= w.min_insp_time_ms &&
            trk_peak >= int'({1'b0, min_peak})) begin
          if (longint'(f) * 100 > longint'(trk_peak) * longint'(w.cycle_off_percent)) begin
            trk_count = '0;
          end else begin
            if (trk_count < count_needed) trk_count++;
            if (trk_count >= count_needed) begin
              r.cycle_request = 1'b1;
              r.cycle_reason  = ReasonFlow;
              if (w.cycle_accepted) clear_tracker();
            end
          end
        end
      end
    end
    r.tracking      = trk_active;
    r.peak_flow     = trk_peak[PeakW-1:0];
    r.confirm_count = trk_count;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches_o++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fcod_out_t want;
    fcod_out_t got;
    if (!rst_ni) begin
      clear_tracker();
      min_peak     = MinPeakRst;
      count_needed = ConfirmRst;
      pending_words.delete();
      mismatches_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // retire first: a word leaving now belongs to an older tick
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_words.size() == 0) begin
          mismatches_o++;
          $display("%0t ns: result word with no tick pending, expected none, got %h",
                   $time, got);
        end else begin
          want = pending_words.pop_front();
          checked_o++;
          check_field("cycle_request", 32'(want.cycle_request), 32'(got.cycle_request));
          check_field("cycle_reason", 32'(want.cycle_reason), 32'(got.cycle_reason));
          check_field("tracking", 32'(want.tracking), 32'(got.tracking));
          check_field("peak_flow", 32'(want.peak_flow), 32'(got.peak_flow));
          check_field("confirm_count", 32'(want.confirm_count), 32'(got.confirm_count));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          REG_MIN_PEAK_FLOW:  min_peak     = cfg_ch.data.wdata[PeakW-1:0];
          REG_CONFIRM_NEEDED: count_needed = cfg_ch.data.wdata[CountW-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) pending_words.push_back(decide_tick(in_ch.data));
      pending_o = pending_words.size();
    end
  end

endmodule

FILE: verif/tb.sv
// Top of the flow cycle-off detector testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import fcod_pkg::*;

  localparam int NumPhases     = 8;
  localparam int TicksPerPhase = 220;
  // cycles with no handshake on any channel before the run is declared hung
  localparam int WatchdogLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni;

  fcod_in_if  in_ch ();
  fcod_out_if out_ch ();
  fcod_cfg_if cfg_ch ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;

  // idle knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // register values last written; shape the breaths so cycling is reachable
  int cur_min_peak = 1000;
  int cur_need     = 3;

  int unsigned ticks_sent = 0;
  int          idle_cycles = 0;

  flow_cycle_off_detector_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  cycle_off_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: ready redrawn every falling edge.
  always @(negedge clk_i) begin
    out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any accepted word on any channel resets the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic fcod_in_t mk_tick(input logic [31:0] now, input logic insp,
                                       input logic elig, input logic [31:0] seq,
                                       input logic [31:0] maxt, input logic [31:0] rise,
                                       input logic [31:0] mint, input logic [6:0] pct,
                                       input logic [15:0] flow, input logic fv,
                                       input logic acc);
    fcod_in_t w;
    w.now_ms            = now;
    w.in_inspiration    = insp;
    w.plan_eligible     = elig;
    w.plan_sequence     = seq;
    w.max_insp_time_ms  = maxt;
    w.rise_time_ms      = rise;
    w.min_insp_time_ms  = mint;
    w.cycle_off_percent = pct;
    w.flow              = flow;
    w.flow_valid        = fv;
    w.cycle_accepted    = acc;
    return w;
  endfunction

  // Offer one tick word. Entered and left at a falling edge; valid is left
  // high so back-to-back words need no extra edge.
  task automatic put_tick(input fcod_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Drain: stop offering, then wait for every result.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input fcod_reg_e idx, input logic [CfgDataW-1:0] v);
    fcod_cfg_wr_t wr;
    wr.index = idx;
    wr.wdata = v;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= wr;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic load_settings(input int min_peak, input int need);
    write_reg(REG_MIN_PEAK_FLOW, CfgDataW'(min_peak));
    write_reg(REG_CONFIRM_NEEDED, CfgDataW'(need));
    cfg_ch.valid <= 1'b0;
    cur_min_peak = min_peak;
    cur_need     = need;
  endtask

  // Fully random word; mostly lands idle or restarts, covers every field bit.
  task automatic noise_tick();
    put_tick(mk_tick($urandom, 1'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
                     $urandom, 7'($urandom_range(127)), 16'($urandom), 1'($urandom),
                     1'($urandom)));
  endtask

  // One pressure-support breath: flow ramps to a peak then decays with noise,
  // followed by a few expiration ticks.
  task automatic run_breath();
    logic [31:0] seq, now, maxt, rise, mint;
    logic [6:0]  pct;
    int          peak_goal, f, fn, len, ramp;
    bit          long_hold;
    seq       = $urandom;
    now       = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(30)) : $urandom;
    long_hold = (cur_need > 30);
    len       = long_hold ? $urandom_range(cur_need, cur_need + 60) : $urandom_range(6, 60);
    maxt      = ($urandom_range(6) == 0) ? $urandom : 32'($urandom_range(len / 2, len * 2));
    rise      = $urandom_range(0, 12);
    mint      = $urandom_range(0, 20);
    pct       = ($urandom_range(9) == 0) ? 7'($urandom_range(101, 127))
                                         : 7'($urandom_range(5, 100));
    if ($urandom_range(4) == 0) peak_goal = $urandom_range(0, 32767);
    else peak_goal = cur_min_peak + $urandom_range(0, 4000);
    if (peak_goal > 32767) peak_goal = 32767;
    ramp = $urandom_range(1, 8);
    f    = 0;
    for (int k = 0; k < len; k++) begin
      if (k < ramp) f = peak_goal * (k + 1) / ramp;
      else f = f - f / 6;
      fn = f + $urandom_range(0, 40) - 20;
      if (fn > 32767) fn = 32767;
      // plan swapped mid-breath now and then
      if ($urandom_range(49) == 0) seq = $urandom;
      put_tick(mk_tick(now, 1'b1, 1'b1, seq, maxt, rise, mint, pct, 16'(fn),
                       long_hold ? ($urandom_range(399) != 0) : ($urandom_range(24) != 0),
                       $urandom_range(3) != 0));
      now += ($urandom_range(19) == 0) ? 32'($urandom_range(2, 5)) : 32'd1;
    end
    repeat ($urandom_range(1, 4)) begin
      put_tick(mk_tick(now, 1'b0, 1'($urandom), seq, maxt, rise, mint, pct,
                       16'($urandom_range(0, 65535)), 1'b1, 1'b0));
      now += 32'd1;
    end
  endtask

  initial begin
    int unsigned phase_start;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed ticks under reset settings (min peak 1000, three confirms).
    // not in inspiration, then plan not eligible
    put_tick(mk_tick(0, 1'b0, 1'b1, 5, 50, 2, 3, 7'd25, 16'd2000, 1'b1, 1'b1));
    put_tick(mk_tick(1, 1'b1, 1'b0, 5, 50, 2, 3, 7'd25, 16'd2000, 1'b1, 1'b1));
    // breath start, peak climbs, invalid sample clears the count
    put_tick(mk_tick(100, 1'b1, 1'b1, 5, 50, 2, 3, 7'd25, 16'd2000, 1'b1, 1'b0));
    put_tick(mk_tick(101, 1'b1, 1'b1, 5, 50, 2, 3, 7'd25, 16'd3000, 1'b1, 1'b0));
    put_tick(mk_tick(102, 1'b1, 1'b1, 5, 50, 2, 3, 7'd25, 16'd3000, 1'b0, 1'b0));
    // below threshold, exactly at threshold, just above it
    put_tick(mk_tick(103, 1'b1, 1'b1, 5, 50, 2, 3, 7'd25, 16'd700, 1'b1, 1'b0));
    put_tick(mk_tick(104, 1'b1, 1'b1, 5, 50, 2, 3, 7'd25, 16'd750, 1'b1, 1'b0));
    put_tick(mk_tick(105, 1'b1, 1'b1, 5, 50, 2, 3, 7'd25, 16'd751, 1'b1, 1'b0));
    // three confirms, request rejected and repeated, then accepted
    put_tick(mk_tick(106, 1'b1, 1'b1, 5, 50, 2, 3, 7'd25, 16'd100, 1'b1, 1'b0));
    put_tick(mk_tick(107, 1'b1, 1'b1, 5, 50, 2, 3, 7'd25, 16'd100, 1'b1, 1'b0));
    put_tick(mk_tick(108, 1'b1, 1'b1, 5, 50, 2, 3, 7'd25, 16'd100, 1'b1, 1'b0));
    put_tick(mk_tick(109, 1'b1, 1'b1, 5, 50, 2, 3, 7'd25, 16'd0, 1'b1, 1'b0));
    put_tick(mk_tick(110, 1'b1, 1'b1, 5, 50, 2, 3, 7'd25, 16'h8000, 1'b1, 1'b1));
    // all-ones plan times, top flow and percent, then negative flow
    put_tick(mk_tick(200, 1'b1, 1'b1, '1, '1, '1, '1, 7'd127, 16'h7FFF, 1'b1, 1'b1));
    put_tick(mk_tick(201, 1'b1, 1'b1, '1, '1, '1, '1, 7'd127, 16'hFFFF, 1'b1, 1'b1));
    // sequence change restarts; zero max time forces a time cycle
    put_tick(mk_tick(202, 1'b1, 1'b1, 7, 0, 0, 0, 7'd50, 16'd1500, 1'b1, 1'b0));
    put_tick(mk_tick(203, 1'b1, 1'b1, 7, 0, 0, 0, 7'd50, 16'd1500, 1'b1, 1'b1));
    // elapsed time across the 32-bit wrap, percent zero
    put_tick(mk_tick(32'hFFFF_FFFE, 1'b1, 1'b1, 8, 5, 0, 0, 7'd0, 16'd1500, 1'b1, 1'b0));
    put_tick(mk_tick(32'h0000_0002, 1'b1, 1'b1, 8, 5, 0, 0, 7'd0, 16'd0, 1'b1, 1'b0));
    put_tick(mk_tick(32'h0000_0003, 1'b1, 1'b1, 8, 5, 0, 0, 7'd0, 16'd0, 1'b1, 1'b0));
    put_tick(mk_tick(32'h0000_0004, 1'b1, 1'b1, 8, 5, 0, 0, 7'd0, 16'd0, 1'b1, 1'b1));
    // percent 100: flow equal to peak still confirms
    put_tick(mk_tick(5, 1'b1, 1'b1, 9, 100, 0, 0, 7'd100, 16'd1200, 1'b1, 1'b1));
    put_tick(mk_tick(6, 1'b1, 1'b1, 9, 100, 0, 0, 7'd100, 16'd1200, 1'b1, 1'b1));
    put_tick(mk_tick(7, 1'b1, 1'b1, 9, 100, 0, 0, 7'd100, 16'd1199, 1'b1, 1'b1));
    put_tick(mk_tick(8, 1'b0, 1'b0, 9, 100, 0, 0, 7'd100, 16'd0, 1'b1, 1'b1));
    settle();

    // Random phases: each one new register settings and one of four idle patterns.
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: load_settings(1000, 3);
        1: load_settings(0, 0);
        2: load_settings(32767, 255);
        3: load_settings(0, 1);
        4: load_settings(700, 8);
        5: load_settings(32767, 0);
        6: load_settings($urandom_range(0, 32767), $urandom_range(0, 12));
        default: load_settings(200, 2);
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < TicksPerPhase) begin
        if ($urandom_range(9) == 0) noise_tick();
        else run_breath();
      end
      settle();
    end

    $display("Sent %0d tick words over %0d phases of settings and idling; %0d results checked.",
             ticks_sent, NumPhases, checked);
    $display("Covered idle/eligible gating, time and flow cycles, wrap, zero and full counts.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
